### rtl/core/rnht_pkg.sv
// Shared types and codes for the next hop routing table.
// No dependencies; imported by rnht_ram, rnht_ctrl and route_next_hop_table.
`timescale 1ns / 1ps
`default_nettype none

package rnht_pkg;

    localparam int ADDR_W = 48;

    typedef logic [ADDR_W-1:0] t_addr;

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_LOOKUP = 2'd1,
        FUNC_CLEAR  = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_MISS
    } t_state;

    typedef struct packed {
        t_addr key;
        t_addr hop;
    } t_row;

endpackage

`default_nettype wire

### rtl/core/route_next_hop_table.sv
// Exact-match next hop table keyed by 48-bit destination address.
// Depends on rnht_pkg, rnht_ram and rnht_ctrl.
//
//   channel   | handshake          | payload
//   ----------+--------------------+-------------------------------------
//   request   | start / busy       | i_func, i_dest_addr, i_next_hop
//   result    | o_done (1 cycle)   | o_status, o_found_next_hop
//
// A request is taken when start is high and busy is low; one result
// follows for each request. Clear and unused codes answer in the next
// cycle; add and lookup scan the N filled entries with the single RAM
// read port and one 48-bit comparator, S_READ then S_CMP per entry.
// Synchronous active-low reset empties the table.
// The receiver cannot stall; o_done marks the single valid cycle.
`timescale 1ns / 1ps
`default_nettype none

module route_next_hop_table #(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire logic [1:0]      i_func,
    input  wire rnht_pkg::t_addr i_dest_addr,
    input  wire rnht_pkg::t_addr i_next_hop,
    output logic                 o_done,
    output logic [1:0]           o_status,
    output rnht_pkg::t_addr      o_found_next_hop
);
    import rnht_pkg::*;

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_row          wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_row          rd_data;

    rnht_ctrl #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_func           (i_func),
        .i_dest_addr      (i_dest_addr),
        .i_next_hop       (i_next_hop),
        .o_busy           (busy),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_found_next_hop (o_found_next_hop),
        .o_wr_en          (wr_en),
        .o_wr_addr        (wr_addr),
        .o_wr_data        (wr_data),
        .o_rd_en          (rd_en),
        .o_rd_addr        (rd_addr),
        .i_rd_data        (rd_data)
    );

    rnht_ram #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

`default_nettype wire

### rtl/core/rnht_ram.sv
// Route storage: one write port, one registered read port.
// Depends on rnht_pkg for the row type.
`timescale 1ns / 1ps
`default_nettype none

module rnht_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire rnht_pkg::t_row i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output rnht_pkg::t_row     o_rd_data
);
    import rnht_pkg::*;

    t_row r_mem [DEPTH];
    t_row r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### rtl/core/rnht_ctrl.sv
// Sequencer and shared key comparator: scans the filled prefix of the table.
// Depends on rnht_pkg; drives the ports of rnht_ram.
`timescale 1ns / 1ps
`default_nettype none

module rnht_ctrl #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [1:0]       i_func,
    input  wire rnht_pkg::t_addr  i_dest_addr,
    input  wire rnht_pkg::t_addr  i_next_hop,
    output logic                  o_busy,
    output logic                  o_done,
    output logic [1:0]            o_status,
    output rnht_pkg::t_addr       o_found_next_hop,
    output logic                  o_wr_en,
    output logic [AW-1:0]         o_wr_addr,
    output rnht_pkg::t_row        o_wr_data,
    output logic                  o_rd_en,
    output logic [AW-1:0]         o_rd_addr,
    input  wire rnht_pkg::t_row   i_rd_data
);
    import rnht_pkg::*;

    t_state  r_state, n_state;
    t_func   r_func, n_func;
    t_addr   r_key, n_key;
    t_addr   r_hop, n_hop;
    logic [AW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_count, n_count;
    logic    r_done, n_done;
    t_status r_status, n_status;
    t_addr   r_found, n_found;
    logic    hit;
    logic    last;

    // Entries fill lowest index first and only a clear or reset frees them,
    // so the valid entries are always slots 0 .. r_count-1.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_key    <= n_key;
        r_hop    <= n_hop;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_found  <= n_found;
    end

    assign hit  = (i_rd_data.key == r_key);
    assign last = ((CW'(r_idx) + CW'(1)) == r_count);

    always_comb begin
        n_state   = r_state;
        n_func    = r_func;
        n_key     = r_key;
        n_hop     = r_hop;
        n_idx     = r_idx;
        n_count   = r_count;
        n_done    = 1'b0;
        n_status  = r_status;
        n_found   = r_found;
        o_wr_en   = 1'b0;
        o_wr_addr = r_idx;
        o_wr_data = '{key: r_key, hop: r_hop};
        o_rd_en   = 1'b0;
        o_rd_addr = r_idx;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_func   = t_func'(i_func);
                    n_key    = i_dest_addr;
                    n_hop    = i_next_hop;
                    n_idx    = '0;
                    n_status = ST_OK;
                    n_found  = '0;
                    case (t_func'(i_func))
                        FUNC_ADD, FUNC_LOOKUP: begin
                            n_state = (r_count == '0) ? S_MISS : S_READ;
                        end
                        FUNC_CLEAR: begin
                            n_count = '0;
                            n_done  = 1'b1;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                o_rd_en = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (hit) begin
                    if (r_func == FUNC_ADD) begin
                        o_wr_en = 1'b1;
                    end else begin
                        n_found = i_rd_data.hop;
                    end
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (last) begin
                    n_state = S_MISS;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = S_READ;
                end
            end
            S_MISS: begin
                if (r_func == FUNC_ADD) begin
                    if (r_count == CW'(DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        o_wr_en   = 1'b1;
                        o_wr_addr = r_count[AW-1:0];
                        n_count   = r_count + CW'(1);
                    end
                end else begin
                    n_status = ST_NOT_FOUND;
                end
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy           = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_found_next_hop = r_found;

endmodule

`default_nettype wire

### verif/rnht_route_checker.sv
// Route table checker: watches the request and result ports of route_next_hop_table,
// keeps its own copy of the table to predict every status and next hop, and compares.
// Depends on rnht_pkg.
`timescale 1ns / 1ps

module rnht_route_checker
    import rnht_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic       i_busy,
    input  wire logic [1:0] i_func,
    input  t_addr           i_dest_addr,
    input  t_addr           i_next_hop,
    input  wire logic       i_done,
    input  wire logic [1:0] i_status,
    input  t_addr           i_found_next_hop,
    output int              o_fail_count,
    output int              o_pending
);

    typedef struct {
        t_status status;
        t_addr   hop;
    } route_reply_t;

    bit    route_used [TABLE_ENTRIES];
    t_addr route_key  [TABLE_ENTRIES];
    t_addr route_hop  [TABLE_ENTRIES];

    route_reply_t expected_replies [$];
    int           mismatch_n = 0;
    int           pending_n  = 0;

    assign o_fail_count = mismatch_n;
    assign o_pending    = pending_n;

    function automatic int find_route(input t_addr dest);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (route_used[i] && route_key[i] == dest) begin
                return i;
            end
        end
        return -1;
    endfunction

    task automatic apply_route_request(input logic [1:0] func, input t_addr dest,
                                       input t_addr hop, output route_reply_t reply);
        int slot;
        reply.status = ST_OK;
        reply.hop    = '0;
        case (func)
            FUNC_ADD: begin
                slot = find_route(dest);
                if (slot < 0) begin
                    for (int i = 0; i < TABLE_ENTRIES && slot < 0; i++) begin
                        if (!route_used[i]) begin
                            slot = i;
                        end
                    end
                    if (slot < 0) begin
                        reply.status = ST_FULL;
                    end else begin
                        route_used[slot] = 1'b1;
                        route_key[slot]  = dest;
                        route_hop[slot]  = hop;
                    end
                end else begin
                    route_hop[slot] = hop;
                end
            end
            FUNC_LOOKUP: begin
                slot = find_route(dest);
                if (slot < 0) begin
                    reply.status = ST_NOT_FOUND;
                end else begin
                    reply.hop = route_hop[slot];
                end
            end
            FUNC_CLEAR: begin
                route_used = '{default: 1'b0};
            end
            default: begin
                // unused code: no state change, ok status
            end
        endcase
    endtask

    always @(posedge i_clk) begin : monitor
        route_reply_t want;
        bit           bad;
        if (!i_rst_n) begin
            route_used = '{default: 1'b0};
            expected_replies.delete();
        end else begin
            // retire the result first; a new request taken on the same edge queues behind it
            if (i_done) begin
                if (expected_replies.size() == 0) begin
                    $display("%0t: result with no request waiting: status %0d next hop %h",
                             $time, i_status, i_found_next_hop);
                    mismatch_n++;
                end else begin
                    want = expected_replies.pop_front();
                    bad  = 1'b0;
                    if (i_status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, want.status, i_status);
                        bad = 1'b1;
                    end
                    if (i_found_next_hop !== want.hop) begin
                        $display("%0t: next hop mismatch: expected %h actual %h",
                                 $time, want.hop, i_found_next_hop);
                        bad = 1'b1;
                    end
                    if (bad) begin
                        mismatch_n++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                apply_route_request(i_func, i_dest_addr, i_next_hop, want);
                expected_replies.push_back(want);
            end
        end
        pending_n = expected_replies.size();
    end

endmodule

### verif/testbench.sv
// Top of the route table testbench: clock, reset, request stimulus, watchdog and verdict.
// Depends on rnht_pkg, route_next_hop_table and rnht_route_checker.
`timescale 1ns / 1ps

module testbench;
    import rnht_pkg::*;

    localparam int          TABLE_ENTRIES = 64;
    localparam int          RANDOM_ITEMS  = 700;
    localparam int          STALL_LIMIT   = 20 * TABLE_ENTRIES + 200;
    localparam logic [1:0]  FUNC_UNUSED   = 2'd3;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [1:0] req_func;
    t_addr      req_dest;
    t_addr      req_hop;
    logic       o_done;
    logic [1:0] o_status;
    t_addr      o_found_next_hop;
    int         fail_count;
    int         pending;
    int         sent = 0;
    int         stall_cycles = 0;

    always #4 i_clk = ~i_clk;

    route_next_hop_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (req_func),
        .i_dest_addr     (req_dest),
        .i_next_hop      (req_hop),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_found_next_hop(o_found_next_hop)
    );

    rnht_route_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) route_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_func          (req_func),
        .i_dest_addr     (req_dest),
        .i_next_hop      (req_hop),
        .i_done          (o_done),
        .i_status        (o_status),
        .i_found_next_hop(o_found_next_hop),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic t_addr random_addr();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            return '0;
        end else if (pick == 1) begin
            return '1;
        end
        return {16'($urandom), 32'($urandom)};
    endfunction

    task automatic send_request(input logic [1:0] func, input t_addr dest, input t_addr hop);
        int gap;
        // no idling in the middle stretch of the random part
        if (!(sent >= 250 && sent < 400) && $urandom_range(0, 99) < 22) begin
            gap = $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                start <= 1'b0;
            end
        end
        @(negedge i_clk);
        start    <= 1'b1;
        req_func <= func;
        req_dest <= dest;
        req_hop  <= hop;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        sent++;
    endtask

    task automatic drain_routes();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        t_addr      pool [$];
        t_addr      pick;
        bit         fill;
        int         pool_size;
        int         episode_len;
        int         episode;
        int         r;

        start    = 1'b0;
        req_func = FUNC_ADD;
        req_dest = '0;
        req_hop  = '0;
        i_rst_n  = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, unused code, key/hop extremes, update, near miss
        send_request(FUNC_LOOKUP, '0, '1);
        send_request(FUNC_CLEAR, '1, '1);
        send_request(FUNC_UNUSED, '1, '1);
        send_request(FUNC_ADD, '0, '1);
        send_request(FUNC_ADD, '1, '0);
        send_request(FUNC_LOOKUP, '0, '0);
        send_request(FUNC_LOOKUP, '1, '1);
        send_request(FUNC_ADD, '0, 48'h5555_5555_5555);
        send_request(FUNC_LOOKUP, '0, '0);
        send_request(FUNC_LOOKUP, 48'h1, '0);
        send_request(FUNC_LOOKUP, 48'h8000_0000_0000, '1);
        send_request(FUNC_ADD, 48'haaaa_aaaa_aaaa, 48'haaaa_aaaa_aaaa);
        send_request(FUNC_UNUSED, 48'haaaa_aaaa_aaaa, '0);
        send_request(FUNC_LOOKUP, 48'haaaa_aaaa_aaaa, '0);
        send_request(FUNC_CLEAR, '0, '0);
        send_request(FUNC_LOOKUP, '1, '0);
        drain_routes();

        // random episodes, each on a fresh table with its own key pool;
        // fill episodes run the table to full and keep going
        sent    = 0;
        episode = 0;
        while (sent < RANDOM_ITEMS) begin
            fill = (episode == 0) || ($urandom_range(0, 3) == 0);
            pool_size = fill ? $urandom_range(TABLE_ENTRIES + 2, TABLE_ENTRIES + 16)
                             : $urandom_range(4, 48);
            episode_len = fill ? pool_size + $urandom_range(20, 80) : $urandom_range(30, 120);
            pool.delete();
            for (int i = 0; i < pool_size; i++) begin
                if (i > 0 && $urandom_range(0, 3) == 0) begin
                    pool.push_back(pool[i-1] ^ (t_addr'(1) << $urandom_range(0, ADDR_W - 1)));
                end else begin
                    pool.push_back(random_addr());
                end
            end
            send_request(FUNC_CLEAR, random_addr(), random_addr());
            for (int j = 0; j < episode_len && sent < RANDOM_ITEMS; j++) begin
                pick = pool[$urandom_range(0, pool.size() - 1)];
                r    = $urandom_range(0, 99);
                if (fill && j < pool_size) begin
                    send_request(FUNC_ADD, pool[j], random_addr());
                end else if (r < 45) begin
                    send_request(FUNC_ADD, pick, random_addr());
                end else if (r < 85) begin
                    send_request(FUNC_LOOKUP, pick, random_addr());
                end else if (r < 90) begin
                    send_request(FUNC_ADD, random_addr(), random_addr());
                end else if (r < 94) begin
                    send_request(FUNC_LOOKUP, random_addr(), random_addr());
                end else if (r < 97) begin
                    send_request(FUNC_UNUSED, random_addr(), random_addr());
                end else begin
                    send_request(FUNC_CLEAR, random_addr(), random_addr());
                end
            end
            if (episode == 0 || $urandom_range(0, 2) == 0) begin
                drain_routes();
            end
            episode++;
        end

        drain_routes();
        repeat (2 * TABLE_ENTRIES + 8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/rnht_pkg.sv
rtl/core/rnht_ram.sv
rtl/core/rnht_ctrl.sv
rtl/core/route_next_hop_table.sv
verif/rnht_route_checker.sv
verif/testbench.sv
